[hw/rtl/heartbeat_degrade_supervisor_core_macros.svh]
// ----------------------------------------------------------------------------
// Heartbeat degrade supervisor assertion macros
// Concurrent assertion wrappers that compile away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef HEARTBEAT_DEGRADE_SUPERVISOR_CORE_MACROS_SVH
`define HEARTBEAT_DEGRADE_SUPERVISOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define HDSUP_ASSERT_IMPLIES(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error("hdsup assertion failed: same-cycle check");
`define HDSUP_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error("hdsup assertion failed: next-cycle check");
`else
`define HDSUP_ASSERT_IMPLIES(label, clk_s, rstn_s, ante, cons)
`define HDSUP_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons)
`endif

`endif

[hw/rtl/hdsup_pkg.sv]
// ----------------------------------------------------------------------------
// Heartbeat degrade supervisor package
// Shared widths, codes, state encodings and structs of the supervisor.
// ----------------------------------------------------------------------------
package hdsup_pkg;

    localparam int MAX_NODES = 8;
    localparam int IDX_W     = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W     = $clog2(MAX_NODES + 1);

    localparam int FUNC_W    = 2;
    localparam int KEY_W     = 64;
    localparam int TIME_W    = 48;
    localparam int TMO_W     = 16;
    localparam int SETLVL_W  = 3;
    localparam int LEVEL_W   = 2;
    localparam int REASON_W  = 4;
    localparam int SPEED_W   = 5;
    localparam int MARGIN_W  = 5;
    localparam int ADDR_W    = 3;
    localparam int DATA_W    = 32;

    localparam logic [TMO_W-1:0] WARN_RESET = 16'd500;
    localparam logic [TMO_W-1:0] FAIL_RESET = 16'd2000;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_HEARTBEAT = 2'd0,
        FUNC_TICK      = 2'd1,
        FUNC_SET       = 2'd2,
        FUNC_CLEAR     = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SCAN  = 2'd1,
        ST_CLEAR = 2'd2,
        ST_APPLY = 2'd3
    } state_t;

    typedef enum logic {
        REG_WARN_TIMEOUT = 1'b0,
        REG_FAIL_TIMEOUT = 1'b1
    } reg_idx_t;

    localparam logic [LEVEL_W-1:0] LEVEL_FULL    = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_LIMITED = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_MRM     = 2'd2;
    localparam logic [LEVEL_W-1:0] LEVEL_STOP    = 2'd3;

    localparam logic [REASON_W-1:0] REASON_NONE     = 4'd0;
    localparam logic [REASON_W-1:0] REASON_PLANNING = 4'd1;
    localparam logic [REASON_W-1:0] REASON_CONTROL  = 4'd2;

    localparam logic [SPEED_W-1:0] SPEED_MRM_DMS = 5'd30;
    localparam logic [SPEED_W-1:0] SPEED_ZERO    = 5'd0;

    localparam logic [MARGIN_W-1:0] MARGIN_FULL    = 5'd10;
    localparam logic [MARGIN_W-1:0] MARGIN_LIMITED = 5'd15;
    localparam logic [MARGIN_W-1:0] MARGIN_MRM     = 5'd20;
    localparam logic [MARGIN_W-1:0] MARGIN_STOP    = 5'd30;

    typedef struct packed {
        logic match;
        logic live;
        logic late;
        logic fail;
    } node_eval_t;

    typedef struct packed {
        logic             key_we;
        logic             stamp_we;
        logic [IDX_W-1:0] waddr;
    } tbl_wr_t;

endpackage

[hw/rtl/hdsup_cmd_if.sv]
// ----------------------------------------------------------------------------
// Heartbeat degrade supervisor command channel
// Valid/ready channel carrying one command word into the supervisor.
// ----------------------------------------------------------------------------
interface hdsup_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [hdsup_pkg::FUNC_W-1:0]        func;
    logic [hdsup_pkg::KEY_W-1:0]         node_key;
    logic [hdsup_pkg::TIME_W-1:0]        now_ms;
    logic [hdsup_pkg::SETLVL_W-1:0]      set_level;
    logic [hdsup_pkg::REASON_W-1:0]      set_reason;

    modport source (
        output valid, func, node_key, now_ms, set_level, set_reason,
        input  ready
    );

    modport sink (
        input  valid, func, node_key, now_ms, set_level, set_reason,
        output ready
    );
endinterface

[hw/rtl/hdsup_act_if.sv]
// ----------------------------------------------------------------------------
// Heartbeat degrade supervisor action channel
// Valid/ready channel carrying one action word out of the supervisor.
// ----------------------------------------------------------------------------
interface hdsup_act_if;
    logic                                valid;
    logic                                ready;
    logic [hdsup_pkg::LEVEL_W-1:0]       level;
    logic [hdsup_pkg::REASON_W-1:0]      reason;
    logic [hdsup_pkg::TIME_W-1:0]        level_time_ms;
    logic                                no_lane_change;
    logic                                inlane_stop;
    logic                                hard_stop;
    logic [hdsup_pkg::SPEED_W-1:0]       speed_limit_dms;
    logic [hdsup_pkg::MARGIN_W-1:0]      safety_margin_tenths;
    logic                                heartbeat_taken;

    modport source (
        output valid, level, reason, level_time_ms, no_lane_change, inlane_stop,
               hard_stop, speed_limit_dms, safety_margin_tenths, heartbeat_taken,
        input  ready
    );

    modport sink (
        input  valid, level, reason, level_time_ms, no_lane_change, inlane_stop,
               hard_stop, speed_limit_dms, safety_margin_tenths, heartbeat_taken,
        output ready
    );
endinterface

[hw/rtl/hdsup_node_table.sv]
// ----------------------------------------------------------------------------
// Heartbeat degrade supervisor node table
// Key and stamp memories with a registered read port, followed by the shared
// entry evaluator that matches the key and ages the stamp against both limits.
// ----------------------------------------------------------------------------
module hdsup_node_table (
    input  logic                              clk,
    input  logic                              rd_en,
    input  logic [hdsup_pkg::IDX_W-1:0]       rd_addr,
    input  hdsup_pkg::tbl_wr_t                wr,
    input  logic [hdsup_pkg::KEY_W-1:0]       key_wdata,
    input  logic [hdsup_pkg::TIME_W-1:0]      stamp_wdata,
    input  logic [hdsup_pkg::KEY_W-1:0]       node_key,
    input  logic [hdsup_pkg::TIME_W-1:0]      now_ms,
    input  logic [hdsup_pkg::TMO_W-1:0]       warn_timeout,
    input  logic [hdsup_pkg::TMO_W-1:0]       fail_timeout,
    output hdsup_pkg::node_eval_t             eval
);

    logic [hdsup_pkg::KEY_W-1:0]  key_mem   [hdsup_pkg::MAX_NODES];
    logic [hdsup_pkg::TIME_W-1:0] stamp_mem [hdsup_pkg::MAX_NODES];

    logic [hdsup_pkg::KEY_W-1:0]  key_q_reg;
    logic [hdsup_pkg::TIME_W-1:0] stamp_q_reg;
    logic [hdsup_pkg::TIME_W:0]   age_diff;
    logic                         age_neg;

    always_ff @(posedge clk)
    begin
        if (wr.key_we)
        begin
            key_mem[wr.waddr] <= key_wdata;
        end
        if (wr.stamp_we)
        begin
            stamp_mem[wr.waddr] <= stamp_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            key_q_reg   <= key_mem[rd_addr];
            stamp_q_reg <= stamp_mem[rd_addr];
        end
    end

    // A stamp in the future gives a negative difference and counts as age zero.
    assign age_diff = {1'b0, now_ms} - {1'b0, stamp_q_reg};
    assign age_neg  = age_diff[hdsup_pkg::TIME_W];

    always_comb
    begin
        eval.match = (key_q_reg == node_key);
        eval.live  = (stamp_q_reg != '0);
        eval.late  = !age_neg &&
                     (age_diff[hdsup_pkg::TIME_W-1:0] > hdsup_pkg::TIME_W'(warn_timeout));
        eval.fail  = !age_neg &&
                     (age_diff[hdsup_pkg::TIME_W-1:0] > hdsup_pkg::TIME_W'(fail_timeout));
    end

endmodule

[hw/rtl/heartbeat_degrade_supervisor_core.sv]
// ----------------------------------------------------------------------------
// Heartbeat degrade supervisor core
// A heartbeat or tick passes IDLE, SCAN and APPLY (a heartbeat leaves SCAN early on a key
// match), a clear passes IDLE, CLEAR and APPLY, and a manual set goes from IDLE to APPLY.
// One word is in work at a time; the next is accepted once the current action word has
// been committed, and APPLY waits while the action register is full and not taken.
// Reset is asynchronous and active low; the node table needs no clearing pass.
// ----------------------------------------------------------------------------
`include "heartbeat_degrade_supervisor_core_macros.svh"

module heartbeat_degrade_supervisor_core (
    input  logic                              clk,
    input  logic                              rst_n,
    hdsup_cmd_if.sink                         cmd,
    hdsup_act_if.source                       act,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hdsup_pkg::ADDR_W-1:0]      paddr,
    input  logic [hdsup_pkg::DATA_W-1:0]      pwdata,
    output logic [hdsup_pkg::DATA_W-1:0]      prdata,
    output logic                              pready
);

    hdsup_pkg::state_t state_reg, state_next;

    hdsup_pkg::func_t                    func_reg;
    logic [hdsup_pkg::KEY_W-1:0]         key_reg;
    logic [hdsup_pkg::TIME_W-1:0]        now_reg;
    logic [hdsup_pkg::SETLVL_W-1:0]      set_level_reg;
    logic [hdsup_pkg::REASON_W-1:0]      set_reason_reg;

    logic [hdsup_pkg::TMO_W-1:0]         warn_reg;
    logic [hdsup_pkg::TMO_W-1:0]         fail_reg;

    logic [hdsup_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic [hdsup_pkg::LEVEL_W-1:0]       level_reg, level_next;
    logic [hdsup_pkg::REASON_W-1:0]      reason_reg, reason_next;
    logic [hdsup_pkg::TIME_W-1:0]        entry_reg, entry_next;
    logic                                lane_lock_reg, lane_lock_next;
    logic [hdsup_pkg::SPEED_W-1:0]       speed_reg, speed_next;

    logic [hdsup_pkg::CNT_W-1:0]         idx_reg, idx_next;
    logic                                pend_vld_reg, pend_vld_next;
    logic [hdsup_pkg::IDX_W-1:0]         pend_idx_reg, pend_idx_next;
    logic [1:0]                          late_cnt_reg, late_cnt_next;
    logic [1:0]                          fail_cnt_reg, fail_cnt_next;
    logic                                n0_late_reg, n0_late_next;
    logic                                n0_fail_reg, n0_fail_next;
    logic                                hit_reg, hit_next;
    logic [hdsup_pkg::IDX_W-1:0]         hit_idx_reg, hit_idx_next;

    logic                                act_vld_reg, act_vld_next;
    logic [hdsup_pkg::LEVEL_W-1:0]       o_level_reg;
    logic [hdsup_pkg::REASON_W-1:0]      o_reason_reg;
    logic [hdsup_pkg::TIME_W-1:0]        o_time_reg;
    logic                                o_nlc_reg;
    logic                                o_mrm_reg;
    logic                                o_imm_reg;
    logic [hdsup_pkg::SPEED_W-1:0]       o_speed_reg;
    logic [hdsup_pkg::MARGIN_W-1:0]      o_margin_reg;
    logic                                o_taken_reg;

    logic                                accept;
    logic                                commit;
    logic                                table_full;
    logic                                rd_en;
    hdsup_pkg::tbl_wr_t                  tbl_wr;
    logic [hdsup_pkg::TIME_W-1:0]        stamp_wdata;
    hdsup_pkg::node_eval_t               eval;

    logic                                esc;
    logic [hdsup_pkg::LEVEL_W-1:0]       esc_level;
    logic [hdsup_pkg::REASON_W-1:0]      esc_reason;
    logic                                do_apply;
    logic [hdsup_pkg::LEVEL_W-1:0]       apply_level;
    logic [hdsup_pkg::REASON_W-1:0]      apply_reason;
    logic                                taken;

    logic                                o_nlc;
    logic                                o_mrm;
    logic                                o_imm;
    logic [hdsup_pkg::SPEED_W-1:0]       o_speed;
    logic [hdsup_pkg::MARGIN_W-1:0]      o_margin;

    logic                                cfg_wr;
    hdsup_pkg::reg_idx_t                 cfg_idx;

    assign accept     = cmd.valid && cmd.ready;
    assign commit     = (state_reg == hdsup_pkg::ST_APPLY) && (!act_vld_reg || act.ready);
    assign table_full = (cnt_reg >= hdsup_pkg::CNT_W'(hdsup_pkg::MAX_NODES));
    assign cmd.ready  = (state_reg == hdsup_pkg::ST_IDLE);

    // Configuration port.
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = hdsup_pkg::reg_idx_t'(paddr[2]);

    always_comb
    begin
        unique case (cfg_idx)
            hdsup_pkg::REG_WARN_TIMEOUT: prdata = hdsup_pkg::DATA_W'(warn_reg);
            hdsup_pkg::REG_FAIL_TIMEOUT: prdata = hdsup_pkg::DATA_W'(fail_reg);
            default:                     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warn_reg <= hdsup_pkg::WARN_RESET;
            fail_reg <= hdsup_pkg::FAIL_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_idx)
                hdsup_pkg::REG_WARN_TIMEOUT: warn_reg <= pwdata[hdsup_pkg::TMO_W-1:0];
                hdsup_pkg::REG_FAIL_TIMEOUT: fail_reg <= pwdata[hdsup_pkg::TMO_W-1:0];
                default:                     ;
            endcase
        end
    end

    hdsup_node_table u_table (
        .clk          (clk),
        .rd_en        (rd_en),
        .rd_addr      (idx_reg[hdsup_pkg::IDX_W-1:0]),
        .wr           (tbl_wr),
        .key_wdata    (key_reg),
        .stamp_wdata  (stamp_wdata),
        .node_key     (key_reg),
        .now_ms       (now_reg),
        .warn_timeout (warn_reg),
        .fail_timeout (fail_reg),
        .eval         (eval)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            hdsup_pkg::ST_IDLE:
            begin
                if (cmd.valid)
                begin
                    unique case (hdsup_pkg::func_t'(cmd.func))
                        hdsup_pkg::FUNC_HEARTBEAT: state_next = hdsup_pkg::ST_SCAN;
                        hdsup_pkg::FUNC_TICK:      state_next = hdsup_pkg::ST_SCAN;
                        hdsup_pkg::FUNC_SET:       state_next = hdsup_pkg::ST_APPLY;
                        hdsup_pkg::FUNC_CLEAR:     state_next = hdsup_pkg::ST_CLEAR;
                        default:                   state_next = hdsup_pkg::ST_IDLE;
                    endcase
                end
            end
            hdsup_pkg::ST_SCAN:
            begin
                if ((pend_vld_reg && eval.match && func_reg == hdsup_pkg::FUNC_HEARTBEAT) ||
                    (idx_reg == cnt_reg))
                begin
                    state_next = hdsup_pkg::ST_APPLY;
                end
            end
            hdsup_pkg::ST_CLEAR:
            begin
                if (idx_reg == cnt_reg)
                begin
                    state_next = hdsup_pkg::ST_APPLY;
                end
            end
            hdsup_pkg::ST_APPLY:
            begin
                if (commit)
                begin
                    state_next = hdsup_pkg::ST_IDLE;
                end
            end
            default: state_next = hdsup_pkg::ST_IDLE;
        endcase
    end

    // Escalation decision from the scan counts.
    always_comb
    begin
        esc        = 1'b0;
        esc_level  = hdsup_pkg::LEVEL_FULL;
        esc_reason = hdsup_pkg::REASON_NONE;
        priority if (fail_cnt_reg >= 2'd2)
        begin
            esc        = (level_reg < hdsup_pkg::LEVEL_STOP);
            esc_level  = hdsup_pkg::LEVEL_STOP;
            esc_reason = hdsup_pkg::REASON_PLANNING;
        end
        else if (fail_cnt_reg == 2'd1)
        begin
            esc        = (level_reg < hdsup_pkg::LEVEL_MRM);
            esc_level  = hdsup_pkg::LEVEL_MRM;
            esc_reason = n0_fail_reg ? hdsup_pkg::REASON_PLANNING : hdsup_pkg::REASON_CONTROL;
        end
        else if (late_cnt_reg >= 2'd2)
        begin
            esc        = (level_reg < hdsup_pkg::LEVEL_MRM);
            esc_level  = hdsup_pkg::LEVEL_MRM;
            esc_reason = hdsup_pkg::REASON_PLANNING;
        end
        else if (late_cnt_reg == 2'd1)
        begin
            esc        = (level_reg < hdsup_pkg::LEVEL_LIMITED);
            esc_level  = hdsup_pkg::LEVEL_LIMITED;
            esc_reason = n0_late_reg ? hdsup_pkg::REASON_PLANNING : hdsup_pkg::REASON_CONTROL;
        end
        else
        begin
            esc = 1'b0;
        end
    end

    // Datapath and table control.
    always_comb
    begin
        cnt_next       = cnt_reg;
        level_next     = level_reg;
        reason_next    = reason_reg;
        entry_next     = entry_reg;
        lane_lock_next = lane_lock_reg;
        speed_next     = speed_reg;
        idx_next       = idx_reg;
        pend_vld_next  = 1'b0;
        pend_idx_next  = pend_idx_reg;
        late_cnt_next  = late_cnt_reg;
        fail_cnt_next  = fail_cnt_reg;
        n0_late_next   = n0_late_reg;
        n0_fail_next   = n0_fail_reg;
        hit_next       = hit_reg;
        hit_idx_next   = hit_idx_reg;
        rd_en          = 1'b0;
        tbl_wr         = '0;
        stamp_wdata    = now_reg;
        do_apply       = 1'b0;
        apply_level    = hdsup_pkg::LEVEL_FULL;
        apply_reason   = hdsup_pkg::REASON_NONE;
        taken          = 1'b0;

        if (accept)
        begin
            idx_next      = '0;
            late_cnt_next = 2'd0;
            fail_cnt_next = 2'd0;
            hit_next      = 1'b0;
        end

        unique case (state_reg)
            hdsup_pkg::ST_SCAN:
            begin
                if (idx_reg < cnt_reg)
                begin
                    rd_en         = 1'b1;
                    idx_next      = hdsup_pkg::CNT_W'(idx_reg + 1'b1);
                    pend_vld_next = 1'b1;
                    pend_idx_next = idx_reg[hdsup_pkg::IDX_W-1:0];
                end
                if (pend_vld_reg)
                begin
                    if (eval.live && eval.late && late_cnt_reg != 2'd2)
                    begin
                        late_cnt_next = late_cnt_reg + 2'd1;
                    end
                    if (eval.live && eval.fail && fail_cnt_reg != 2'd2)
                    begin
                        fail_cnt_next = fail_cnt_reg + 2'd1;
                    end
                    if (pend_idx_reg == '0)
                    begin
                        n0_late_next = eval.late;
                        n0_fail_next = eval.fail;
                    end
                    if (eval.match && func_reg == hdsup_pkg::FUNC_HEARTBEAT && !hit_reg)
                    begin
                        hit_next     = 1'b1;
                        hit_idx_next = pend_idx_reg;
                    end
                end
            end
            hdsup_pkg::ST_CLEAR:
            begin
                stamp_wdata = '0;
                if (idx_reg < cnt_reg)
                begin
                    tbl_wr.stamp_we = 1'b1;
                    tbl_wr.waddr    = idx_reg[hdsup_pkg::IDX_W-1:0];
                    idx_next        = hdsup_pkg::CNT_W'(idx_reg + 1'b1);
                end
            end
            hdsup_pkg::ST_APPLY:
            begin
                unique case (func_reg)
                    hdsup_pkg::FUNC_HEARTBEAT:
                    begin
                        taken = hit_reg || !table_full;
                        if (commit)
                        begin
                            if (hit_reg)
                            begin
                                tbl_wr.stamp_we = 1'b1;
                                tbl_wr.waddr    = hit_idx_reg;
                            end
                            else if (!table_full)
                            begin
                                tbl_wr.key_we   = 1'b1;
                                tbl_wr.stamp_we = 1'b1;
                                tbl_wr.waddr    = cnt_reg[hdsup_pkg::IDX_W-1:0];
                                cnt_next        = hdsup_pkg::CNT_W'(cnt_reg + 1'b1);
                            end
                        end
                    end
                    hdsup_pkg::FUNC_TICK:
                    begin
                        do_apply     = esc;
                        apply_level  = esc_level;
                        apply_reason = esc_reason;
                    end
                    hdsup_pkg::FUNC_SET:
                    begin
                        do_apply     = !set_level_reg[hdsup_pkg::SETLVL_W-1];
                        apply_level  = set_level_reg[hdsup_pkg::LEVEL_W-1:0];
                        apply_reason = set_reason_reg;
                    end
                    hdsup_pkg::FUNC_CLEAR:
                    begin
                        level_next     = hdsup_pkg::LEVEL_FULL;
                        reason_next    = hdsup_pkg::REASON_NONE;
                        entry_next     = '0;
                        lane_lock_next = 1'b0;
                        speed_next     = hdsup_pkg::SPEED_ZERO;
                    end
                    default: ;
                endcase

                if (do_apply)
                begin
                    level_next  = apply_level;
                    reason_next = apply_reason;
                    entry_next  = (func_reg == hdsup_pkg::FUNC_TICK) ? now_reg : '0;
                    if (apply_level >= hdsup_pkg::LEVEL_LIMITED)
                    begin
                        lane_lock_next = 1'b1;
                    end
                    if (apply_level == hdsup_pkg::LEVEL_MRM)
                    begin
                        speed_next = hdsup_pkg::SPEED_MRM_DMS;
                    end
                    if (apply_level == hdsup_pkg::LEVEL_STOP)
                    begin
                        speed_next = hdsup_pkg::SPEED_ZERO;
                    end
                end
            end
            default: ;
        endcase
    end

    // Action fields implied by the updated level.
    always_comb
    begin
        o_nlc    = 1'b0;
        o_mrm    = 1'b0;
        o_imm    = 1'b0;
        o_speed  = hdsup_pkg::SPEED_ZERO;
        o_margin = hdsup_pkg::MARGIN_FULL;
        unique case (level_next)
            hdsup_pkg::LEVEL_FULL: ;
            hdsup_pkg::LEVEL_LIMITED:
            begin
                o_nlc    = lane_lock_next;
                o_speed  = speed_next;
                o_margin = hdsup_pkg::MARGIN_LIMITED;
            end
            hdsup_pkg::LEVEL_MRM:
            begin
                o_nlc    = 1'b1;
                o_mrm    = 1'b1;
                o_speed  = (speed_next != '0) ? speed_next : hdsup_pkg::SPEED_MRM_DMS;
                o_margin = hdsup_pkg::MARGIN_MRM;
            end
            hdsup_pkg::LEVEL_STOP:
            begin
                o_nlc    = 1'b1;
                o_mrm    = 1'b1;
                o_imm    = 1'b1;
                o_margin = hdsup_pkg::MARGIN_STOP;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        act_vld_next = act_vld_reg;
        if (commit)
        begin
            act_vld_next = 1'b1;
        end
        else if (act.ready)
        begin
            act_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= hdsup_pkg::ST_IDLE;
            cnt_reg       <= '0;
            level_reg     <= hdsup_pkg::LEVEL_FULL;
            reason_reg    <= hdsup_pkg::REASON_NONE;
            entry_reg     <= '0;
            lane_lock_reg <= 1'b0;
            speed_reg     <= hdsup_pkg::SPEED_ZERO;
            idx_reg       <= '0;
            pend_vld_reg  <= 1'b0;
            late_cnt_reg  <= 2'd0;
            fail_cnt_reg  <= 2'd0;
            hit_reg       <= 1'b0;
            act_vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            level_reg     <= level_next;
            reason_reg    <= reason_next;
            entry_reg     <= entry_next;
            lane_lock_reg <= lane_lock_next;
            speed_reg     <= speed_next;
            idx_reg       <= idx_next;
            pend_vld_reg  <= pend_vld_next;
            late_cnt_reg  <= late_cnt_next;
            fail_cnt_reg  <= fail_cnt_next;
            hit_reg       <= hit_next;
            act_vld_reg   <= act_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_idx_reg <= pend_idx_next;
        n0_late_reg  <= n0_late_next;
        n0_fail_reg  <= n0_fail_next;
        hit_idx_reg  <= hit_idx_next;
        if (accept)
        begin
            func_reg       <= hdsup_pkg::func_t'(cmd.func);
            key_reg        <= cmd.node_key;
            now_reg        <= cmd.now_ms;
            set_level_reg  <= cmd.set_level;
            set_reason_reg <= cmd.set_reason;
        end
        if (commit)
        begin
            o_level_reg  <= level_next;
            o_reason_reg <= reason_next;
            o_time_reg   <= entry_next;
            o_nlc_reg    <= o_nlc;
            o_mrm_reg    <= o_mrm;
            o_imm_reg    <= o_imm;
            o_speed_reg  <= o_speed;
            o_margin_reg <= o_margin;
            o_taken_reg  <= taken;
        end
    end

    assign act.valid                = act_vld_reg;
    assign act.level                = o_level_reg;
    assign act.reason               = o_reason_reg;
    assign act.level_time_ms        = o_time_reg;
    assign act.no_lane_change       = o_nlc_reg;
    assign act.inlane_stop          = o_mrm_reg;
    assign act.hard_stop            = o_imm_reg;
    assign act.speed_limit_dms      = o_speed_reg;
    assign act.safety_margin_tenths = o_margin_reg;
    assign act.heartbeat_taken      = o_taken_reg;

    `HDSUP_ASSERT_IMPLIES(a_idle_no_read_pending, clk, rst_n, cmd.ready, !pend_vld_reg)
    `HDSUP_ASSERT_NEXT(a_tick_never_lowers, clk, rst_n, commit && func_reg == hdsup_pkg::FUNC_TICK, level_reg >= $past(level_reg))
    `HDSUP_ASSERT_NEXT(a_new_node_registered, clk, rst_n, commit && func_reg == hdsup_pkg::FUNC_HEARTBEAT && !hit_reg && !table_full, cnt_reg == hdsup_pkg::CNT_W'($past(cnt_reg) + 1'b1))

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// Heartbeat degrade supervisor testbench
// Drives command words into the supervisor core and checks every action word
// against a cycle-free model of the node table and the escalation ladder.
// A short directed sequence is followed by random phases under several
// timeout settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import hdsup_pkg::*;

    localparam int NODE_POOL    = 12;
    localparam int PHASES       = 7;
    localparam int CHUNK_WORDS  = 60;
    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 20;

    typedef struct {
        func_t                 func;
        logic [KEY_W-1:0]      node_key;
        logic [TIME_W-1:0]     now_ms;
        logic [SETLVL_W-1:0]   set_level;
        logic [REASON_W-1:0]   set_reason;
    } command_t;

    typedef struct {
        logic [LEVEL_W-1:0]    level;
        logic [REASON_W-1:0]   reason;
        logic [TIME_W-1:0]     level_time_ms;
        logic                  no_lane_change;
        logic                  inlane_stop;
        logic                  hard_stop;
        logic [SPEED_W-1:0]    speed_limit_dms;
        logic [MARGIN_W-1:0]   safety_margin_tenths;
        logic                  heartbeat_taken;
    } action_t;

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [ADDR_W-1:0]    paddr;
    logic [DATA_W-1:0]    pwdata;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;

    hdsup_cmd_if cmd_ch ();
    hdsup_act_if act_ch ();

    heartbeat_degrade_supervisor_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd_ch),
        .act     (act_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    command_t           command_q[$];
    action_t            action_q[$];
    command_t           on_bus;
    action_t            arrived;
    action_t            wanted;

    logic [TMO_W-1:0]   warn_ms;
    logic [TMO_W-1:0]   fail_ms;
    logic [KEY_W-1:0]   slot_key [MAX_NODES];
    logic [TIME_W-1:0]  slot_stamp [MAX_NODES];
    int unsigned        slots_used;
    logic [LEVEL_W-1:0] cur_level;
    logic [REASON_W-1:0] cur_reason;
    logic [TIME_W-1:0]  level_entry;
    logic               lane_lock;
    logic [SPEED_W-1:0] held_speed;

    logic [KEY_W-1:0]   node_pool [NODE_POOL];
    logic [TIME_W-1:0]  clock_ms;
    logic [TMO_W-1:0]   warn_set [PHASES];
    logic [TMO_W-1:0]   fail_set [PHASES];
    bit                 calm;
    int unsigned        mismatches;
    int unsigned        words_sent;
    int unsigned        words_in;
    int unsigned        words_out;
    int unsigned        dropped_beats;
    int unsigned        escalations;
    int unsigned        quiet_cycles;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    function automatic logic [TIME_W-1:0] rand48();
        return {16'($urandom), $urandom};
    endfunction

    function automatic logic [KEY_W-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic void apply_level(logic [SETLVL_W-1:0] lvl, logic [REASON_W-1:0] rsn);
        if (lvl > SETLVL_W'(LEVEL_STOP))
            return;
        cur_level   = lvl[LEVEL_W-1:0];
        cur_reason  = rsn;
        level_entry = '0;
        if (lvl >= SETLVL_W'(LEVEL_LIMITED))
            lane_lock = 1'b1;
        if (lvl >= SETLVL_W'(LEVEL_MRM))
            held_speed = SPEED_MRM_DMS;
        if (lvl == SETLVL_W'(LEVEL_STOP))
            held_speed = SPEED_ZERO;
    endfunction

    function automatic void escalate(logic [LEVEL_W-1:0] lvl, logic [REASON_W-1:0] rsn,
                                     logic [TIME_W-1:0] now);
        apply_level(SETLVL_W'(lvl), rsn);
        level_entry = now;
        escalations++;
    endfunction

    function automatic logic [REASON_W-1:0] node0_reason(logic [TIME_W-1:0] now,
                                                         logic [TMO_W-1:0] limit);
        logic [63:0] deadline;
        deadline = 64'(slot_stamp[0]) + 64'(limit);
        return (deadline < 64'(now)) ? REASON_PLANNING : REASON_CONTROL;
    endfunction

    function automatic action_t supervise(command_t c);
        action_t           a;
        int unsigned       hit;
        int unsigned       late_n;
        int unsigned       failed_n;
        int unsigned       i;
        logic [TIME_W-1:0] age;
        a.heartbeat_taken = 1'b0;
        case (c.func)
            FUNC_HEARTBEAT:
            begin
                hit = MAX_NODES;
                for (i = 0; i < slots_used; i++)
                    if (hit == MAX_NODES && slot_key[i] == c.node_key)
                        hit = i;
                if (hit == MAX_NODES && slots_used < MAX_NODES)
                begin
                    hit = slots_used;
                    slot_key[hit] = c.node_key;
                    slots_used++;
                end
                if (hit != MAX_NODES)
                begin
                    slot_stamp[hit] = c.now_ms;
                    a.heartbeat_taken = 1'b1;
                end
                else
                    dropped_beats++;
            end
            FUNC_TICK:
            begin
                late_n = 0;
                failed_n = 0;
                for (i = 0; i < slots_used; i++)
                begin
                    if (slot_stamp[i] != '0)
                    begin
                        age = (c.now_ms > slot_stamp[i]) ? c.now_ms - slot_stamp[i] : '0;
                        if (age > warn_ms)
                            late_n++;
                        if (age > fail_ms)
                            failed_n++;
                    end
                end
                if (failed_n >= 2)
                begin
                    if (cur_level < LEVEL_STOP)
                        escalate(LEVEL_STOP, REASON_PLANNING, c.now_ms);
                end
                else if (failed_n == 1)
                begin
                    if (cur_level < LEVEL_MRM)
                        escalate(LEVEL_MRM, node0_reason(c.now_ms, fail_ms), c.now_ms);
                end
                else if (late_n >= 2)
                begin
                    if (cur_level < LEVEL_MRM)
                        escalate(LEVEL_MRM, REASON_PLANNING, c.now_ms);
                end
                else if (late_n == 1)
                begin
                    if (cur_level < LEVEL_LIMITED)
                        escalate(LEVEL_LIMITED, node0_reason(c.now_ms, warn_ms), c.now_ms);
                end
            end
            FUNC_SET:
                apply_level(c.set_level, c.set_reason);
            default:
            begin
                cur_level   = LEVEL_FULL;
                cur_reason  = REASON_NONE;
                level_entry = '0;
                lane_lock   = 1'b0;
                held_speed  = SPEED_ZERO;
                for (i = 0; i < slots_used; i++)
                    slot_stamp[i] = '0;
            end
        endcase

        a.level                = cur_level;
        a.reason               = cur_reason;
        a.level_time_ms        = level_entry;
        a.no_lane_change       = 1'b0;
        a.inlane_stop          = 1'b0;
        a.hard_stop            = 1'b0;
        a.speed_limit_dms      = SPEED_ZERO;
        a.safety_margin_tenths = MARGIN_FULL;
        case (cur_level)
            LEVEL_LIMITED:
            begin
                a.no_lane_change       = lane_lock;
                a.speed_limit_dms      = held_speed;
                a.safety_margin_tenths = MARGIN_LIMITED;
            end
            LEVEL_MRM:
            begin
                a.no_lane_change       = 1'b1;
                a.inlane_stop          = 1'b1;
                a.speed_limit_dms      = (held_speed != SPEED_ZERO) ? held_speed : SPEED_MRM_DMS;
                a.safety_margin_tenths = MARGIN_MRM;
            end
            LEVEL_STOP:
            begin
                a.no_lane_change       = 1'b1;
                a.inlane_stop          = 1'b1;
                a.hard_stop            = 1'b1;
                a.safety_margin_tenths = MARGIN_STOP;
            end
            default:
            begin
            end
        endcase
        return a;
    endfunction

    function automatic void queue_command(func_t f, logic [KEY_W-1:0] key,
                                          logic [TIME_W-1:0] now, logic [SETLVL_W-1:0] lvl,
                                          logic [REASON_W-1:0] rsn);
        command_t c;
        c.func       = f;
        c.node_key   = key;
        c.now_ms     = now;
        c.set_level  = lvl;
        c.set_reason = rsn;
        command_q.push_back(c);
    endfunction

    function automatic void queue_random();
        int unsigned       pick;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] lag;
        logic [KEY_W-1:0]  key;
        pick = $urandom_range(99);
        key  = node_pool[$urandom_range(NODE_POOL - 1)];
        if (pick < 45)
        begin
            clock_ms = clock_ms + TIME_W'($urandom_range(0, warn_ms / 4 + 1));
            now = ($urandom_range(19) == 0) ? '0 : clock_ms;
            queue_command(FUNC_HEARTBEAT, key, now, 3'($urandom), 4'($urandom));
        end
        else if (pick < 75)
        begin
            case ($urandom_range(5))
                0: lag = TIME_W'(warn_ms);
                1: lag = TIME_W'(warn_ms) + 1;
                2: lag = TIME_W'(fail_ms);
                3: lag = TIME_W'(fail_ms) + 1;
                4: lag = TIME_W'($urandom_range(0, 2 * fail_ms + 2));
                default: lag = '0;
            endcase
            if (lag == '0)
                now = clock_ms - TIME_W'($urandom_range(0, warn_ms));
            else
                now = clock_ms + lag;
            if (now > clock_ms && $urandom_range(1) == 1)
                clock_ms = now;
            queue_command(FUNC_TICK, rand64(), now, 3'($urandom), 4'($urandom));
        end
        else if (pick < 85)
            queue_command(FUNC_CLEAR, rand64(), rand48(), 3'($urandom), 4'($urandom));
        else if (pick < 93)
            queue_command(FUNC_SET, rand64(), rand48(), 3'($urandom), 4'($urandom));
        else
            queue_command(func_t'($urandom_range(3)), ($urandom_range(1) == 1) ? key : rand64(),
                          rand48(), 3'($urandom), 4'($urandom));
    endfunction

    function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Every word taken from the queue must have come back as an action word.
    task automatic drain();
        do
            @(posedge clk);
        while (command_q.size() != 0 || words_sent != words_out);
    endtask

    task automatic program_register(reg_idx_t idx, logic [TMO_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_WARN_TIMEOUT)
            warn_ms = value;
        else
            fail_ms = value;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
            cmd_ch.valid <= 1'b0;
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
            begin
                action_q.push_back(supervise(on_bus));
                words_in++;
            end
            if (!cmd_ch.valid || cmd_ch.ready)
            begin
                if (command_q.size() != 0 && (calm || $urandom_range(99) >= 7))
                begin
                    on_bus = command_q.pop_front();
                    words_sent++;
                    cmd_ch.valid      <= 1'b1;
                    cmd_ch.func       <= on_bus.func;
                    cmd_ch.node_key   <= on_bus.node_key;
                    cmd_ch.now_ms     <= on_bus.now_ms;
                    cmd_ch.set_level  <= on_bus.set_level;
                    cmd_ch.set_reason <= on_bus.set_reason;
                end
                else
                    cmd_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            act_ch.ready <= 1'b0;
        else
        begin
            if (act_ch.valid && act_ch.ready)
            begin
                words_out++;
                arrived.level                = act_ch.level;
                arrived.reason               = act_ch.reason;
                arrived.level_time_ms        = act_ch.level_time_ms;
                arrived.no_lane_change       = act_ch.no_lane_change;
                arrived.inlane_stop          = act_ch.inlane_stop;
                arrived.hard_stop            = act_ch.hard_stop;
                arrived.speed_limit_dms      = act_ch.speed_limit_dms;
                arrived.safety_margin_tenths = act_ch.safety_margin_tenths;
                arrived.heartbeat_taken      = act_ch.heartbeat_taken;
                if (action_q.size() == 0)
                begin
                    $error("action word arrived with no command outstanding");
                    mismatches++;
                end
                else
                begin
                    wanted = action_q.pop_front();
                    compare_field("level", wanted.level, arrived.level);
                    compare_field("reason", wanted.reason, arrived.reason);
                    compare_field("level_time_ms", wanted.level_time_ms, arrived.level_time_ms);
                    compare_field("no_lane_change", wanted.no_lane_change,
                                  arrived.no_lane_change);
                    compare_field("inlane_stop", wanted.inlane_stop, arrived.inlane_stop);
                    compare_field("hard_stop", wanted.hard_stop, arrived.hard_stop);
                    compare_field("speed_limit_dms", wanted.speed_limit_dms,
                                  arrived.speed_limit_dms);
                    compare_field("safety_margin_tenths", wanted.safety_margin_tenths,
                                  arrived.safety_margin_tenths);
                    compare_field("heartbeat_taken", wanted.heartbeat_taken,
                                  arrived.heartbeat_taken);
                end
            end
            act_ch.ready <= calm || ($urandom_range(99) >= 7);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (act_ch.valid && act_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("heartbeat_degrade_supervisor_core: mismatch");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        cmd_ch.valid      = 1'b0;
        cmd_ch.func       = FUNC_HEARTBEAT;
        cmd_ch.node_key   = '0;
        cmd_ch.now_ms     = '0;
        cmd_ch.set_level  = '0;
        cmd_ch.set_reason = '0;
        act_ch.ready      = 1'b0;
        calm              = 1'b0;
        mismatches        = 0;
        words_sent        = 0;
        words_in          = 0;
        words_out         = 0;
        dropped_beats     = 0;
        escalations       = 0;
        quiet_cycles      = 0;

        warn_ms     = WARN_RESET;
        fail_ms     = FAIL_RESET;
        slots_used  = 0;
        cur_level   = LEVEL_FULL;
        cur_reason  = REASON_NONE;
        level_entry = '0;
        lane_lock   = 1'b0;
        held_speed  = SPEED_ZERO;

        node_pool[0] = '0;
        node_pool[1] = '1;
        for (int k = 2; k < NODE_POOL; k++)
            node_pool[k] = rand64();

        warn_set = '{WARN_RESET, 16'd1, 16'hFFFF, 16'd200, 16'd900,
                     16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535))};
        fail_set = '{FAIL_RESET, 16'd1, 16'hFFFF, 16'd800, 16'd300,
                     16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535))};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed sequence under the reset timeouts of 500 and 2000 ms.
        queue_command(FUNC_TICK, rand64(), '0, 3'd0, 4'd0);
        queue_command(FUNC_HEARTBEAT, node_pool[0], 48'd1000, 3'd0, 4'd0);
        queue_command(FUNC_TICK, rand64(), 48'd1501, 3'd0, 4'd0);
        queue_command(FUNC_HEARTBEAT, node_pool[1], '0, 3'd7, 4'hF);
        queue_command(FUNC_CLEAR, '0, '0, 3'd0, 4'd0);
        queue_command(FUNC_HEARTBEAT, node_pool[0], 48'd5000, 3'd0, 4'd0);
        queue_command(FUNC_HEARTBEAT, node_pool[1], 48'd4000, 3'd0, 4'd0);
        queue_command(FUNC_TICK, rand64(), 48'd4600, 3'd0, 4'd0);
        queue_command(FUNC_TICK, rand64(), 48'd6100, 3'd0, 4'd0);
        queue_command(FUNC_TICK, rand64(), 48'd8000, 3'd0, 4'd0);
        queue_command(FUNC_SET, '1, '1, 3'd7, 4'hF);
        queue_command(FUNC_SET, '0, '0, 3'd1, 4'hF);
        queue_command(FUNC_SET, '0, '0, 3'd2, 4'd9);
        queue_command(FUNC_SET, '0, '0, 3'd1, 4'd8);
        queue_command(FUNC_SET, '0, '0, 3'd0, 4'd10);
        queue_command(FUNC_CLEAR, '1, '1, 3'd7, 4'hF);
        for (int k = 2; k < MAX_NODES; k++)
            queue_command(FUNC_HEARTBEAT, node_pool[k], '1, 3'd0, 4'd0);
        queue_command(FUNC_HEARTBEAT, node_pool[MAX_NODES], 48'd100, 3'd0, 4'd0);
        queue_command(FUNC_HEARTBEAT, node_pool[0], 48'h8000_0000_0000, 3'd0, 4'd0);
        queue_command(FUNC_TICK, rand64(), '1, 3'd0, 4'd0);
        queue_command(FUNC_TICK, rand64(), '0, 3'd0, 4'd0);
        queue_command(FUNC_SET, '0, '0, 3'd3, 4'd0);
        queue_command(FUNC_CLEAR, '0, '0, 3'd0, 4'd0);
        drain();

        for (int p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                program_register(REG_WARN_TIMEOUT, warn_set[p]);
                program_register(REG_FAIL_TIMEOUT, fail_set[p]);
            end
            calm = (p == 2);
            clock_ms = rand48();
            if (clock_ms < 48'h10_0000)
                clock_ms = clock_ms + 48'h10_0000;
            if (clock_ms > 48'hFFFF_F000_0000)
                clock_ms = clock_ms - 48'h1000_0000;
            for (int chunk = 0; chunk < 2; chunk++)
            begin
                for (int n = 0; n < CHUNK_WORDS; n++)
                    queue_random();
                drain();
            end
        end
        calm = 1'b0;

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d action words for %0d command words under %0d timeout settings.",
                 words_out, words_in, PHASES);
        $display("The ladder escalated %0d times and %0d heartbeats found the node table full.",
                 escalations, dropped_beats);
        if (mismatches == 0 && action_q.size() == 0)
            $display("heartbeat_degrade_supervisor_core: match");
        else
            $display("heartbeat_degrade_supervisor_core: mismatch");
        $finish;
    end
endmodule
